@@ rtl/scpa_pkg.sv @@
// shared widths, codes and control types of the size class pool allocator
package scpa_pkg;

   localparam int ADDR_W      = 18;
   localparam int ADDR_SPACE  = 262144;
   localparam int SIZE_W      = 16;
   localparam int ALIGN_W     = 13;
   localparam int STATUS_W    = 3;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 24;

   // req_tuser codes
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // rsp_tuser codes
   localparam logic [STATUS_W-1:0] ST_POOL     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_CARVED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UPSTREAM = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OOM      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FREED    = 3'd4;

   typedef struct packed {
      logic clear_en;   // write one empty list head, step the sweep
      logic capture;    // take the request, read its class head
      logic link_rd;    // read the link entry behind the head
      logic commit;     // update the lists or carve state, load the response
   } scpa_cmd_type;

   typedef struct packed {
      logic clear_last; // sweep is at the last class
      logic is_pop;     // captured request pops a non-empty list
   } scpa_sts_type;

endpackage

@@ rtl/scpa_ctrl.sv @@
// request sequencer: clearing sweep, capture, link read and commit
module scpa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output scpa_pkg::scpa_cmd_type cmd,
   input  scpa_pkg::scpa_sts_type sts
);
   import scpa_pkg::*;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;
   localparam logic [1:0] S_LINK  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.is_pop) begin
               cmd.link_rd = 1'b1;
               state_in    = S_LINK;
            end else if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_LINK: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   assign rsp_valid_in = cmd.commit ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/scpa_dpath.sv @@
// list head and link memories, size class decode, chunk carving and response register
module scpa_dpath #(
   parameter int MAX_BLOCK_BYTES = 256,
   parameter int CHUNK_BYTES     = 16384,
   parameter int CHUNK_COUNT     = 16,
   parameter int ALIGN_BYTES     = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  scpa_pkg::scpa_cmd_type         cmd,
   output scpa_pkg::scpa_sts_type         sts,
   input  logic [scpa_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,
   output logic [scpa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [scpa_pkg::STATUS_W-1:0]   rsp_tuser
);
   import scpa_pkg::*;

   localparam int CLASS_COUNT = MAX_BLOCK_BYTES / ALIGN_BYTES + 1;
   localparam int CLS_W       = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
   localparam int NEED_Q_W    = $clog2(CLASS_COUNT + 1);
   localparam int NEED_W      = $clog2(CLASS_COUNT * ALIGN_BYTES + 1);
   localparam int OFF_W       = $clog2(CHUNK_BYTES + 1);
   localparam int SUM_W       = ((OFF_W > NEED_W) ? OFF_W : NEED_W) + 1;
   localparam int CH_W        = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
   localparam int LINK_DEPTH  = ADDR_SPACE / ALIGN_BYTES;
   localparam int LINK_W      = $clog2(LINK_DEPTH);
   localparam int HEAD_W      = 1 + ADDR_W + LINK_W;
   // exact floor division by the alignment for any 18-bit value
   localparam int DIV_SHIFT   = ADDR_W + $clog2(ALIGN_BYTES);
   localparam longint DIV_MUL = ((64'd1 << DIV_SHIFT) + ALIGN_BYTES - 1) / ALIGN_BYTES;
   localparam int MUL_W       = $clog2(DIV_MUL + 1);
   localparam int PROD_W      = ADDR_W + MUL_W;
   localparam logic [PROD_W-1:0] DIV_MUL_C  = PROD_W'(DIV_MUL);
   localparam logic [ADDR_W-1:0] CHUNK_STEP = ADDR_W'(CHUNK_BYTES % ADDR_SPACE);
   localparam logic [SUM_W-1:0]  CHUNK_C    = SUM_W'(CHUNK_BYTES);

   function automatic logic [ADDR_W-1:0] div_align(input logic [ADDR_W-1:0] x);
      logic [PROD_W-1:0] p;
      p = PROD_W'(x) * DIV_MUL_C;
      return ADDR_W'(p >> DIV_SHIFT);
   endfunction

   // request fields
   logic [SIZE_W-1:0]  size_bytes;
   logic [ALIGN_W-1:0] align_bytes;
   logic [ADDR_W-1:0]  block_address;
   assign size_bytes    = req_tdata[SIZE_W-1:0];
   assign align_bytes   = req_tdata[SIZE_W+ALIGN_W-1:SIZE_W];
   assign block_address = req_tdata[SIZE_W+ALIGN_W+ADDR_W-1:SIZE_W+ALIGN_W];

   logic [ADDR_W-1:0] size_q, need_q, baddr_q;
   logic              pool_ok;
   logic [CLS_W-1:0]  cls_rd;
   logic [LINK_W-1:0] bidx;

   always_comb begin
      size_q  = div_align(ADDR_W'(size_bytes));
      need_q  = div_align(ADDR_W'(size_bytes) + ADDR_W'(ALIGN_BYTES - 1));
      baddr_q = div_align(block_address);
      pool_ok = (align_bytes == ALIGN_W'(ALIGN_BYTES)) &&
                (size_bytes <= SIZE_W'(MAX_BLOCK_BYTES)) && (size_q != '0);
      cls_rd  = pool_ok ? size_q[CLS_W-1:0] : '0;
      bidx    = (baddr_q == ADDR_W'(LINK_DEPTH)) ? '0 : baddr_q[LINK_W-1:0];
   end

   // captured request
   logic                action_ff;
   logic                pool_ok_ff;
   logic [CLS_W-1:0]    cls_ff;
   logic [NEED_Q_W-1:0] need_q_ff;
   logic [ADDR_W-1:0]   baddr_ff;
   logic [LINK_W-1:0]   bidx_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff  <= req_tuser;
         pool_ok_ff <= pool_ok;
         cls_ff     <= cls_rd;
         need_q_ff  <= need_q[NEED_Q_W-1:0];
         baddr_ff   <= block_address;
         bidx_ff    <= bidx;
      end
   end

   // list heads: {valid, address, link index}
   logic [HEAD_W-1:0] head_mem [CLASS_COUNT];
   logic [HEAD_W-1:0] head_rd_ff;
   logic [HEAD_W-1:0] head_wd;
   logic [CLS_W-1:0]  head_wa;
   logic              head_we;
   logic [CLS_W-1:0]  sweep_ff;

   // next links: {valid, address, link index}
   logic [HEAD_W-1:0] link_mem [LINK_DEPTH];
   logic [HEAD_W-1:0] link_rd_ff;
   logic              link_we;

   logic              head_valid;
   logic [ADDR_W-1:0] head_addr;
   logic [LINK_W-1:0] head_idx;
   assign head_valid = head_rd_ff[HEAD_W-1];
   assign head_addr  = head_rd_ff[HEAD_W-2:LINK_W];
   assign head_idx   = head_rd_ff[LINK_W-1:0];

   logic is_free, is_pop, is_carve;
   assign is_free  = pool_ok_ff && (action_ff == ACT_FREE);
   assign is_pop   = pool_ok_ff && (action_ff == ACT_ALLOC) && head_valid;
   assign is_carve = pool_ok_ff && (action_ff == ACT_ALLOC) && !head_valid;

   assign sts.is_pop     = is_pop;
   assign sts.clear_last = (sweep_ff == CLS_W'(CLASS_COUNT - 1));

   always_comb begin
      head_we = cmd.clear_en || (cmd.commit && (is_free || is_pop));
      head_wa = cmd.clear_en ? sweep_ff : cls_ff;
      if (cmd.clear_en)
         head_wd = '0;
      else if (is_free)
         head_wd = {1'b1, baddr_ff, bidx_ff};
      else
         head_wd = link_rd_ff;
      link_we = cmd.commit && is_free;
   end

   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_wa] <= head_wd;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) head_rd_ff <= head_mem[cls_rd];
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem[bidx_ff] <= head_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.link_rd) link_rd_ff <= link_mem[head_idx];
   end

   // carving from the current chunk
   logic [OFF_W-1:0]  offset_ff, offset_in;
   logic [CH_W-1:0]   chunk_ff, chunk_in;
   logic [ADDR_W-1:0] chunk_base_ff, chunk_base_in;
   logic [NEED_W-1:0] need;
   logic [SUM_W-1:0]  fit_sum;
   logic              too_big, no_fit, last_chunk, advance, carve_ok;
   logic [ADDR_W-1:0] base_sel, carve_addr;
   logic [OFF_W-1:0]  off_sel;

   always_comb begin
      need       = NEED_W'(need_q_ff) * NEED_W'(ALIGN_BYTES);
      fit_sum    = SUM_W'(offset_ff) + SUM_W'(need);
      too_big    = SUM_W'(need) > CHUNK_C;
      no_fit     = fit_sum > CHUNK_C;
      last_chunk = (chunk_ff == CH_W'(CHUNK_COUNT - 1));
      carve_ok   = !too_big && (!no_fit || !last_chunk);
      advance    = !too_big && no_fit && !last_chunk;
      base_sel   = advance ? chunk_base_ff + CHUNK_STEP : chunk_base_ff;
      off_sel    = advance ? '0 : offset_ff;
      carve_addr = base_sel + ADDR_W'(off_sel);

      offset_in     = offset_ff;
      chunk_in      = chunk_ff;
      chunk_base_in = chunk_base_ff;
      if (cmd.commit && is_carve && carve_ok) begin
         offset_in     = OFF_W'(SUM_W'(off_sel) + SUM_W'(need));
         chunk_in      = advance ? chunk_ff + CH_W'(1) : chunk_ff;
         chunk_base_in = base_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= '0;
         chunk_ff      <= '0;
         chunk_base_ff <= '0;
         sweep_ff      <= '0;
      end else begin
         offset_ff     <= offset_in;
         chunk_ff      <= chunk_in;
         chunk_base_ff <= chunk_base_in;
         if (cmd.clear_en) sweep_ff <= sweep_ff + CLS_W'(1);
      end
   end

   // response register
   logic [ADDR_W-1:0]   res_addr;
   logic [STATUS_W-1:0] res_status;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   always_comb begin
      res_addr = '0;
      priority if (!pool_ok_ff) begin
         res_status = ST_UPSTREAM;
      end else if (is_free) begin
         res_status = ST_FREED;
      end else if (is_pop) begin
         res_status = ST_POOL;
         res_addr   = head_addr;
      end else if (carve_ok) begin
         res_status = ST_CARVED;
         res_addr   = carve_addr;
      end else begin
         res_status = ST_OOM;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_addr_ff   <= res_addr;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_tdata = RSP_DATA_W'(rsp_addr_ff);
   assign rsp_tuser = rsp_status_ff;

endmodule

@@ rtl/size_class_pool_allocator.sv @@
// top level of the size class pool allocator
// Each request transaction allocates or frees one block. A request is served from the
// pools only when its alignment equals ALIGN_BYTES and its size is ALIGN_BYTES to
// MAX_BLOCK_BYTES; everything else gets status "pass to upstream" and address zero. An
// allocation pops the head of its size class list, or carves a block from the current
// chunk (size rounded up to the alignment), stepping to the next of CHUNK_COUNT chunks
// when it does not fit, and reports out of memory when none is left. A free pushes the
// block on its class list. After reset the block sweeps all MAX_BLOCK_BYTES/ALIGN_BYTES+1
// list heads empty, one a cycle, with req_tready low. After that one request is in flight
// at a time: a free, a pass or a carve is captured with its head read, then committed
// to the output register; a pop adds a link read in between, since the head memory read
// must come back before the link memory can be read for the new head. A response waiting
// in the output register does not block the next accept; only the commit waits for it.
module size_class_pool_allocator #(
   parameter int MAX_BLOCK_BYTES = 256,
   parameter int CHUNK_BYTES     = 16384,
   parameter int CHUNK_COUNT     = 16,
   parameter int ALIGN_BYTES     = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: tdata = size_bytes[15:0], align_bytes[28:16], block_address[46:29], pad
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [scpa_pkg::REQ_DATA_W-1:0] req_tdata,
   // request: tuser = action (0 allocate, 1 free)
   input  logic                            req_tuser,
   // response: tdata = address[17:0], pad
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [scpa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // response: tuser = status[2:0]
   output logic [scpa_pkg::STATUS_W-1:0]   rsp_tuser
);
   import scpa_pkg::*;

   scpa_cmd_type cmd;   // sequencer to datapath
   scpa_sts_type sts;   // datapath to sequencer

   scpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   scpa_dpath #(
      .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
      .CHUNK_BYTES     (CHUNK_BYTES),
      .CHUNK_COUNT     (CHUNK_COUNT),
      .ALIGN_BYTES     (ALIGN_BYTES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

@@ rtl/scpa_checker.sv @@
// port level checks of the size class pool allocator and their binding
module scpa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [scpa_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [scpa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [scpa_pkg::STATUS_W-1:0]   rsp_tuser
);
   import scpa_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // one request in flight: no accept right after an accept
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

   // nothing is accepted or presented in the cycle after reset
   a_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_tready && !rsp_tvalid)
      else $error("handshake active right after reset");

   // only pops and carves return an address
   a_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_UPSTREAM || rsp_tuser == ST_OOM ||
                     rsp_tuser == ST_FREED) |-> rsp_tdata == '0)
      else $error("nonzero address on a response without a block");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == ST_POOL || rsp_tuser == ST_CARVED ||
                     rsp_tuser == ST_UPSTREAM || rsp_tuser == ST_OOM ||
                     rsp_tuser == ST_FREED)
      else $error("undefined status code");

endmodule

bind size_class_pool_allocator scpa_checker u_scpa_checker (.*);
